FILE: sv/bdq_pkg.sv
// shared types and constants for the bounded double-ended queue
`default_nettype none

package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int CAP_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // word reported for an empty queue
  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_FRONT,
    S_RD_REAR,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: sv/bounded_double_ended_queue.sv
// bounded double-ended queue of 32-bit words on a ring buffer ram
`default_nettype none

// Bounded deque of signed 32-bit words held in a ring buffer of MAX_DEPTH
// entries, with a head pointer and an entry count in flip-flops. Each request
// (push front, push rear, pop front, pop rear, query) gives one result with
// the accepted flag, the front and rear words after the operation (all ones
// when empty) and the empty and full flags. A request goes through these steps
// in order: the acceptance edge does the write and the pointer update, a read
// of the front slot and then a read of the rear slot are captured through the
// single read port of the ram, and the result is loaded into the output
// register once that register is empty or being taken. The next request is
// taken only after the result is loaded, so the block takes no new request
// while one is in flight; a stalled result holds the sequencer until it is
// taken. Capacity writes are held off while a request is in flight or offered.
// Capacity values above MAX_DEPTH act as MAX_DEPTH; a capacity of zero refuses
// every push. The ram needs no clearing after reset: only words from slots
// written by a push reach the outputs.

module bounded_double_ended_queue #(
  parameter int MAX_DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bdq_pkg::CAP_W-1:0]      cfg_data_i,
  // requests
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [bdq_pkg::OP_W-1:0]       opcode_i,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] push_value_i,
  // results
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                accepted_o,
  output logic signed [bdq_pkg::DATA_W-1:0]   front_value_o,
  output logic signed [bdq_pkg::DATA_W-1:0]   rear_value_o,
  output logic                                is_empty_o,
  output logic                                is_full_o
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int CmpW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
  localparam logic [AW:0]   DepthX = (AW + 1)'(MAX_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(MAX_DEPTH - 1);
  localparam logic [CW-1:0] DepthC = CW'(MAX_DEPTH);

  bdq_pkg::state_e state_q, state_d;

  logic [bdq_pkg::CAP_W-1:0]  capacity_q;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              count_q, count_d;
  logic                       acc_q, acc_d;
  logic [bdq_pkg::DATA_W-1:0] front_q;

  logic                       out_valid_q;
  logic                       out_acc_q, out_empty_q, out_full_q;
  logic [bdq_pkg::DATA_W-1:0] out_front_q, out_rear_q;

  logic                       in_take;
  logic                       full_now;
  logic                       empty_now;
  logic [AW-1:0]              head_dec, head_inc, rear_wr_slot, rear_rd_slot;
  logic [AW:0]                inc_sum, wr_sum, rd_sum;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [bdq_pkg::DATA_W-1:0] rd_data;
  logic                       out_load;

  // configuration register, written only with no request in flight or offered
  assign cfg_ready_o = (state_q == bdq_pkg::S_IDLE) && !in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= bdq_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  // full and empty on the current count
  assign full_now  = (CmpW'(count_q) >= CmpW'(capacity_q)) || (count_q == DepthC);
  assign empty_now = (count_q == '0);

  // ring pointer arithmetic, every sum stays below twice the depth while not empty
  assign head_dec     = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign inc_sum      = {1'b0, head_q} + 1'b1;
  assign head_inc     = (inc_sum == DepthX) ? '0 : inc_sum[AW-1:0];
  assign wr_sum       = {1'b0, head_q} + (AW + 1)'(count_q);
  assign rear_wr_slot = (wr_sum >= DepthX) ? AW'(wr_sum - DepthX) : wr_sum[AW-1:0];
  assign rd_sum       = {1'b0, head_q} + (AW + 1)'(count_q - 1'b1);
  assign rear_rd_slot = (rd_sum >= DepthX) ? AW'(rd_sum - DepthX) : rd_sum[AW-1:0];

  assign in_take = in_valid_i && in_ready_o;

  // opcode decode: pointer update and ram write
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    acc_d   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = rear_wr_slot;
    unique case (opcode_i)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full_now) begin
          head_d  = head_dec;
          count_d = count_q + 1'b1;
          acc_d   = 1'b1;
          wr_en   = in_take;
          wr_addr = head_dec;
        end
      end
      bdq_pkg::OP_PUSH_REAR: begin
        if (!full_now) begin
          count_d = count_q + 1'b1;
          acc_d   = 1'b1;
          wr_en   = in_take;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (!empty_now) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          acc_d   = 1'b1;
        end
      end
      bdq_pkg::OP_POP_REAR: begin
        if (!empty_now) begin
          count_d = count_q - 1'b1;
          acc_d   = 1'b1;
        end
      end
      bdq_pkg::OP_QUERY: begin
        acc_d = 1'b1;
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (in_take) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      acc_q <= acc_d;
    end
    if (state_q == bdq_pkg::S_RD_REAR) begin
      front_q <= rd_data;
    end
  end

  // entry store
  bdq_ram #(
    .Width(bdq_pkg::DATA_W),
    .Depth(MAX_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(push_value_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bdq_pkg::S_RD_FRONT;
        end
      end
      bdq_pkg::S_RD_FRONT: begin
        state_d = bdq_pkg::S_RD_REAR;
      end
      bdq_pkg::S_RD_REAR: begin
        state_d = bdq_pkg::S_DONE;
      end
      bdq_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    out_load   = 1'b0;
    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
      end
      bdq_pkg::S_RD_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      bdq_pkg::S_RD_REAR: begin
        rd_en   = 1'b1;
        rd_addr = rear_rd_slot;
      end
      bdq_pkg::S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q   <= acc_q;
      out_front_q <= empty_now ? bdq_pkg::EMPTY_WORD : front_q;
      out_rear_q  <= empty_now ? bdq_pkg::EMPTY_WORD : rd_data;
      out_empty_q <= empty_now;
      out_full_q  <= full_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_acc_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule

`default_nettype wire

FILE: sv/bdq_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module bdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdq_checker.sv
// port-level checks for the bounded double-ended queue
`default_nettype none

module bdq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          accepted_o,
  input wire logic [bdq_pkg::DATA_W-1:0]    front_value_o,
  input wire logic [bdq_pkg::DATA_W-1:0]    rear_value_o,
  input wire logic                          is_empty_o,
  input wire logic                          is_full_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_value_o)
      && $stable(rear_value_o) && $stable(accepted_o) && $stable(is_empty_o)
      && $stable(is_full_o))
    else $error("result changed while stalled");

  // an empty queue reports all-ones words
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |->
      front_value_o == bdq_pkg::EMPTY_WORD && rear_value_o == bdq_pkg::EMPTY_WORD)
    else $error("empty queue reported a stored word");

  // one request in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another was in flight");

  // no result appears in the cycle after a request is taken while none was pending
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the bounded double-ended queue with a built-in deque predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CLK_PERIOD  = 2;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [bdq_pkg::OP_W-1:0]   op;
    logic [bdq_pkg::DATA_W-1:0] word;
  } request_t;

  typedef struct packed {
    logic                              accepted;
    logic signed [bdq_pkg::DATA_W-1:0] front;
    logic signed [bdq_pkg::DATA_W-1:0] rear;
    logic                              empty;
    logic                              full;
  } deque_view_t;

  logic                              clk_i        = 1'b0;
  logic                              rst_ni       = 1'b0;
  logic                              cfg_valid_i  = 1'b0;
  logic                              cfg_ready_o;
  logic [bdq_pkg::CAP_W-1:0]         cfg_data_i   = bdq_pkg::CAP_RESET;
  logic                              in_valid_i   = 1'b0;
  logic                              in_ready_o;
  logic [bdq_pkg::OP_W-1:0]          opcode_i     = bdq_pkg::OP_QUERY;
  logic signed [bdq_pkg::DATA_W-1:0] push_value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i  = 1'b0;
  logic                              accepted_o;
  logic signed [bdq_pkg::DATA_W-1:0] front_value_o;
  logic signed [bdq_pkg::DATA_W-1:0] rear_value_o;
  logic                              is_empty_o;
  logic                              is_full_o;

  // predictor state: ring of words, head slot, live count, capacity register
  logic [bdq_pkg::DATA_W-1:0] dq_words [DEPTH];
  logic [IDX_W-1:0]           dq_head     = '0;
  int                         dq_count    = 0;
  logic [bdq_pkg::CAP_W-1:0]  dq_capacity = bdq_pkg::CAP_RESET;

  request_t    pending_requests [$];
  deque_view_t expected_views [$];
  int          mismatches  = 0;
  bit          quiet_phase = 1'b0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  bounded_double_ended_queue #(
    .MAX_DEPTH (DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // apply one request to the predicted deque and return what the block should report
  function automatic deque_view_t step_deque(input logic [bdq_pkg::OP_W-1:0] op,
                                             input logic [bdq_pkg::DATA_W-1:0] word);
    deque_view_t view;
    int          limit;
    logic        was_full;
    // capacities above the ring depth behave as the ring depth
    limit    = (int'(dq_capacity) > DEPTH) ? DEPTH : int'(dq_capacity);
    was_full = dq_count >= limit;
    view.accepted = 1'b0;
    case (op)
      bdq_pkg::OP_PUSH_FRONT: if (!was_full) begin
        dq_head           = dq_head - 1'b1;
        dq_words[dq_head] = word;
        dq_count++;
        view.accepted = 1'b1;
      end
      bdq_pkg::OP_PUSH_REAR: if (!was_full) begin
        dq_words[dq_head + IDX_W'(dq_count)] = word;
        dq_count++;
        view.accepted = 1'b1;
      end
      bdq_pkg::OP_POP_FRONT: if (dq_count > 0) begin
        dq_head = dq_head + 1'b1;
        dq_count--;
        view.accepted = 1'b1;
      end
      bdq_pkg::OP_POP_REAR: if (dq_count > 0) begin
        dq_count--;
        view.accepted = 1'b1;
      end
      bdq_pkg::OP_QUERY: view.accepted = 1'b1;
      default: ;
    endcase
    view.empty = dq_count == 0;
    view.full  = dq_count >= limit;
    if (view.empty) begin
      view.front = bdq_pkg::EMPTY_WORD;
      view.rear  = bdq_pkg::EMPTY_WORD;
    end else begin
      view.front = dq_words[dq_head];
      view.rear  = dq_words[dq_head + IDX_W'(dq_count - 1)];
    end
    return view;
  endfunction

  // random word, leaning on the signed extremes
  function automatic logic [bdq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(bdq_pkg::DATA_W-1){1'b0}}};
      1: return {1'b0, {(bdq_pkg::DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random opcode: pushes with the given weight, the rest pops, queries and spare codes
  function automatic logic [bdq_pkg::OP_W-1:0] pick_op(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_REAR : bdq_pkg::OP_PUSH_FRONT;
    case ($urandom_range(0, 9))
      0:          return bdq_pkg::OP_QUERY + bdq_pkg::OP_W'($urandom_range(1, 3));
      1:          return bdq_pkg::OP_QUERY;
      2, 3, 4, 5: return bdq_pkg::OP_POP_FRONT;
      default:    return bdq_pkg::OP_POP_REAR;
    endcase
  endfunction

  task automatic add_request(input logic [bdq_pkg::OP_W-1:0] op,
                             input logic [bdq_pkg::DATA_W-1:0] word);
    request_t req;
    req.op   = op;
    req.word = word;
    pending_requests.push_back(req);
  endtask

  // wait until every request has gone in and every result has come out
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dq_capacity = cap;
    @(negedge clk_i);
  endtask

  // request driver: predicts on acceptance, then offers the next request or idles
  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_views.push_back(step_deque(opcode_i, push_value_i));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= $urandom_range(0, 14);
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          opcode_i     <= nxt.op;
          push_value_i <= nxt.word;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each result with the oldest prediction, stalls at random
  always @(posedge clk_i) begin : check_results
    deque_view_t exp_view;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_views.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          exp_view = expected_views.pop_front();
          if (accepted_o !== exp_view.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_view.accepted, accepted_o);
            mismatches++;
          end
          if (front_value_o !== exp_view.front) begin
            $error("front_value: expected %0d, got %0d", exp_view.front, front_value_o);
            mismatches++;
          end
          if (rear_value_o !== exp_view.rear) begin
            $error("rear_value: expected %0d, got %0d", exp_view.rear, rear_value_o);
            mismatches++;
          end
          if (is_empty_o !== exp_view.empty) begin
            $error("is_empty: expected %0d, got %0d", exp_view.empty, is_empty_o);
            mismatches++;
          end
          if (is_full_o !== exp_view.full) begin
            $error("is_full: expected %0d, got %0d", exp_view.full, is_full_o);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 14);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [bdq_pkg::CAP_W-1:0] cap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue at reset capacity, both ends, extreme words, spare opcodes
    add_request(bdq_pkg::OP_QUERY, pick_word());
    add_request(bdq_pkg::OP_POP_FRONT, pick_word());
    add_request(bdq_pkg::OP_PUSH_FRONT, {1'b0, {(bdq_pkg::DATA_W-1){1'b1}}});
    add_request(bdq_pkg::OP_PUSH_REAR, {1'b1, {(bdq_pkg::DATA_W-1){1'b0}}});
    add_request(bdq_pkg::OP_PUSH_FRONT, '0);
    add_request(bdq_pkg::OP_PUSH_REAR, '1);
    for (int o = int'(bdq_pkg::OP_QUERY) + 1; o < (1 << bdq_pkg::OP_W); o++)
      add_request(bdq_pkg::OP_W'(o), pick_word());
    add_request(bdq_pkg::OP_POP_REAR, pick_word());
    add_request(bdq_pkg::OP_POP_FRONT, pick_word());
    add_request(bdq_pkg::OP_POP_FRONT, pick_word());
    add_request(bdq_pkg::OP_POP_REAR, pick_word());
    add_request(bdq_pkg::OP_POP_REAR, pick_word());
    drain();

    // zero capacity: empty and full at once, every push refused
    write_capacity('0);
    add_request(bdq_pkg::OP_PUSH_FRONT, pick_word());
    add_request(bdq_pkg::OP_PUSH_REAR, pick_word());
    add_request(bdq_pkg::OP_QUERY, pick_word());
    drain();

    // single entry capacity
    write_capacity(bdq_pkg::CAP_W'(1));
    add_request(bdq_pkg::OP_PUSH_REAR, pick_word());
    add_request(bdq_pkg::OP_PUSH_FRONT, pick_word());
    add_request(bdq_pkg::OP_POP_FRONT, pick_word());
    drain();

    // capacity lowered below the live count keeps entries and reports full
    write_capacity('1);
    repeat (3) add_request(bdq_pkg::OP_PUSH_REAR, pick_word());
    drain();
    write_capacity(bdq_pkg::CAP_W'(2));
    add_request(bdq_pkg::OP_PUSH_FRONT, pick_word());
    add_request(bdq_pkg::OP_POP_FRONT, pick_word());
    add_request(bdq_pkg::OP_POP_REAR, pick_word());
    add_request(bdq_pkg::OP_PUSH_REAR, pick_word());
    drain();

    // random phases over a spread of capacities, filling then draining
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       cap = '0;
        1:       cap = bdq_pkg::CAP_W'(1);
        2:       cap = bdq_pkg::CAP_W'(DEPTH);
        3:       cap = '1;
        4:       cap = bdq_pkg::CAP_W'(DEPTH + 1);
        default: cap = bdq_pkg::CAP_W'($urandom_range(2, 24));
      endcase
      write_capacity(cap);
      for (int n = 0; n < 60; n++)
        add_request(pick_op(n < 30 ? 60 : 35), pick_word());
      drain();
    end

    // last phase without idling: fill the whole ring past wrap-around
    write_capacity(bdq_pkg::CAP_W'(DEPTH));
    quiet_phase = 1'b1;
    for (int n = 0; n < 1100; n++)
      add_request(pick_op(97), pick_word());
    drain();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bounded_double_ended_queue.sv
sv/bdq_checker.sv
dv/testbench.sv
